[src/c2u_pkg.sv]
// Shared types and the high-half code table for the CP1251 to UTF-8 encoder.
`default_nettype none

package c2u_pkg;

   localparam int unsigned BYTE_W  = 8;
   localparam int unsigned WORD_W  = 24;
   localparam int unsigned CNT_W   = 2;
   localparam int unsigned IDX_W   = 7;
   localparam int unsigned ROM_DEPTH = 128;

   // UTF-8 bytes for codes 0x80..0xFF, first byte in bits 7:0.
   // A zero word marks the unassigned code.
   localparam logic [WORD_W-1:0] HI_MAP [ROM_DEPTH] = '{
      24'h0082D0, 24'h0083D0, 24'h9A80E2, 24'h0093D1,
      24'h9E80E2, 24'hA680E2, 24'hA080E2, 24'hA180E2,
      24'hAC82E2, 24'hB080E2, 24'h0089D0, 24'hB980E2,
      24'h008AD0, 24'h008CD0, 24'h008BD0, 24'h008FD0,
      24'h0092D1, 24'h9880E2, 24'h9980E2, 24'h9C80E2,
      24'h9D80E2, 24'hA280E2, 24'h9380E2, 24'h9480E2,
      24'h000000, 24'hA284E2, 24'h0099D1, 24'hBA80E2,
      24'h009AD1, 24'h009CD1, 24'h009BD1, 24'h009FD1,
      24'h00A0C2, 24'h008ED0, 24'h009ED1, 24'h0088D0,
      24'h00A4C2, 24'h0090D2, 24'h00A6C2, 24'h00A7C2,
      24'h0081D0, 24'h00A9C2, 24'h0084D0, 24'h00ABC2,
      24'h00ACC2, 24'h00ADC2, 24'h00AEC2, 24'h0087D0,
      24'h00B0C2, 24'h00B1C2, 24'h0086D0, 24'h0096D1,
      24'h0091D2, 24'h00B5C2, 24'h00B6C2, 24'h00B7C2,
      24'h0091D1, 24'h9684E2, 24'h0094D1, 24'h00BBC2,
      24'h0098D1, 24'h0085D0, 24'h0095D1, 24'h0097D1,
      24'h0090D0, 24'h0091D0, 24'h0092D0, 24'h0093D0,
      24'h0094D0, 24'h0095D0, 24'h0096D0, 24'h0097D0,
      24'h0098D0, 24'h0099D0, 24'h009AD0, 24'h009BD0,
      24'h009CD0, 24'h009DD0, 24'h009ED0, 24'h009FD0,
      24'h00A0D0, 24'h00A1D0, 24'h00A2D0, 24'h00A3D0,
      24'h00A4D0, 24'h00A5D0, 24'h00A6D0, 24'h00A7D0,
      24'h00A8D0, 24'h00A9D0, 24'h00AAD0, 24'h00ABD0,
      24'h00ACD0, 24'h00ADD0, 24'h00AED0, 24'h00AFD0,
      24'h00B0D0, 24'h00B1D0, 24'h00B2D0, 24'h00B3D0,
      24'h00B4D0, 24'h00B5D0, 24'h00B6D0, 24'h00B7D0,
      24'h00B8D0, 24'h00B9D0, 24'h00BAD0, 24'h00BBD0,
      24'h00BCD0, 24'h00BDD0, 24'h00BED0, 24'h00BFD0,
      24'h0080D1, 24'h0081D1, 24'h0082D1, 24'h0083D1,
      24'h0084D1, 24'h0085D1, 24'h0086D1, 24'h0087D1,
      24'h0088D1, 24'h0089D1, 24'h008AD1, 24'h008BD1,
      24'h008CD1, 24'h008DD1, 24'h008ED1, 24'h008FD1
   };

   localparam logic [CNT_W-1:0] CNT_NONE  = 2'd0;
   localparam logic [CNT_W-1:0] CNT_ONE   = 2'd1;
   localparam logic [CNT_W-1:0] CNT_TWO   = 2'd2;
   localparam logic [CNT_W-1:0] CNT_THREE = 2'd3;

   // Looked-up character handed from the table stage to the serializer.
   typedef struct packed {
      logic              valid;
      logic [WORD_W-1:0] word;
      logic [CNT_W-1:0]  count;
   } lookup_type;

endpackage

`default_nettype wire

[src/c2u_lookup.sv]
// Input stage: registered table read and byte count for one input beat.
`default_nettype none

module c2u_lookup (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          req_valid,
   output logic                               req_ready,
   input  wire logic [c2u_pkg::BYTE_W-1:0]    req_in_byte,
   input  wire logic                          take,
   output c2u_pkg::lookup_type                lk
);
   import c2u_pkg::*;

   logic                  valid_ff, valid_in;
   logic [BYTE_W-1:0]     byte_ff;
   logic [WORD_W-1:0]     rom_ff;
   logic                  accept;

   assign req_ready = !valid_ff || take;
   assign accept    = req_valid && req_ready;

   always_comb begin
      valid_in = valid_ff;
      if (accept) begin
         valid_in = 1'b1;
      end else if (take) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   // ROM port: registered read, captured with the beat.
   always_ff @(posedge clock) begin
      if (accept) begin
         byte_ff <= req_in_byte;
         rom_ff  <= HI_MAP[req_in_byte[IDX_W-1:0]];
      end
   end

   always_comb begin
      lk.valid = valid_ff;
      if (!byte_ff[BYTE_W-1]) begin
         lk.word  = {{(WORD_W-BYTE_W){1'b0}}, byte_ff};
         lk.count = CNT_ONE;
      end else begin
         lk.word = rom_ff;
         if (rom_ff == '0) begin
            lk.count = CNT_NONE;
         end else if (rom_ff[WORD_W-1 -: BYTE_W] != '0) begin
            lk.count = CNT_THREE;
         end else begin
            lk.count = CNT_TWO;
         end
      end
   end

endmodule

`default_nettype wire

[src/cp1251_to_utf8_encoder_top.sv]
// Top level of the CP1251 to UTF-8 encoder: table stage, serializer, output register.
//
//   channel  direction  handshake              payload
//   req      in         req_valid/req_ready    req_in_byte[7:0]
//   rsp      out        rsp_valid/rsp_ready    rsp_out_byte[7:0], rsp_last
//
// Output runs at one byte per cycle while rsp_ready is high and input keeps up; an input
// yields 1, 2 or 3 UTF-8 bytes, and code 0x98 yields none but still passes through the
// serializer, leaving a gap in the output. The byte serializer sets this rate.
// An accepted req beat passes the table-stage, serializer and output registers.
// Synchronous reset clears the valid flags and the serializer count; data registers are not reset.
// A stalled rsp holds the output register; the serializer and table stage fill
// behind it and req_ready drops once both are occupied.
`default_nettype none

module cp1251_to_utf8_encoder_top (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          req_valid,
   output logic                               req_ready,
   input  wire logic [c2u_pkg::BYTE_W-1:0]    req_in_byte,
   output logic                               rsp_valid,
   input  wire logic                          rsp_ready,
   output logic [c2u_pkg::BYTE_W-1:0]         rsp_out_byte,
   output logic                               rsp_last
);
   import c2u_pkg::*;

   lookup_type           lk;
   logic                 ser_free;

   logic [WORD_W-1:0]    sr_word_ff, sr_word_in;
   logic [CNT_W-1:0]     sr_cnt_ff, sr_cnt_in;

   logic                 rsp_valid_ff, rsp_valid_in;
   logic [BYTE_W-1:0]    rsp_byte_ff;
   logic                 rsp_last_ff;

   logic                 out_load;
   logic                 emit;

   c2u_lookup u_lookup (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_in_byte (req_in_byte),
      .take        (ser_free),
      .lk          (lk)
   );

   // Output register takes a byte whenever it is empty or being drained.
   assign out_load = !rsp_valid_ff || rsp_ready;
   assign emit     = out_load && (sr_cnt_ff != CNT_NONE);

   // Serializer is free for the next character when empty or once its last byte leaves.
   assign ser_free = (sr_cnt_ff == CNT_NONE) || ((sr_cnt_ff == CNT_ONE) && out_load);

   always_comb begin
      sr_word_in = sr_word_ff;
      sr_cnt_in  = sr_cnt_ff;
      if (ser_free && lk.valid) begin
         // load next character; a zero count drops it
         sr_word_in = lk.word;
         sr_cnt_in  = lk.count;
      end else if (emit) begin
         // advance to the next byte
         sr_word_in = {{BYTE_W{1'b0}}, sr_word_ff[WORD_W-1:BYTE_W]};
         sr_cnt_in  = sr_cnt_ff - CNT_ONE;
      end else if (ser_free) begin
         sr_cnt_in  = CNT_NONE;
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (out_load) begin
         rsp_valid_in = emit;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         sr_cnt_ff    <= CNT_NONE;
         rsp_valid_ff <= 1'b0;
      end else begin
         sr_cnt_ff    <= sr_cnt_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      sr_word_ff <= sr_word_in;
      if (emit) begin
         rsp_byte_ff <= sr_word_ff[BYTE_W-1:0];
         rsp_last_ff <= (sr_cnt_ff == CNT_ONE);
      end
   end

   assign rsp_valid    = rsp_valid_ff;
   assign rsp_out_byte = rsp_byte_ff;
   assign rsp_last     = rsp_last_ff;

`ifndef NO_ASSERTIONS
   // A three-byte character always carries a nonzero top byte.
   a_three_nonzero: assert property (@(posedge clock) disable iff (reset)
      (sr_cnt_ff == CNT_THREE) |-> (sr_word_ff[WORD_W-1 -: BYTE_W] != '0))
      else $error("serializer holds three bytes with a zero top byte");

   // The last flag marks exactly the final byte of the serializer.
   a_last_mark: assert property (@(posedge clock) disable iff (reset)
      emit |=> (rsp_last_ff == $past(sr_cnt_ff == CNT_ONE)))
      else $error("rsp_last does not match the serializer count");

   // Input stalls only while the table stage is full and blocked.
   a_stall_cause: assert property (@(posedge clock) disable iff (reset)
      !req_ready |-> (lk.valid && !ser_free))
      else $error("req_ready low without a blocked table stage");
`endif

endmodule

`default_nettype wire
